### rtl/ltlp_pkg.sv
// shared constants, command/status types and a saturation helper for linear_to_level_position
// no dependencies; used by ltlp_ctrl, ltlp_dp and the top level
`timescale 1ns / 1ps

package ltlp_pkg;

  // sizing
  localparam int MAX_LEVELS         = 256;
  localparam int LINEAR_FRAC_BITS   = 16;
  localparam int POSITION_FRAC_BITS = 8;

  localparam int IDX_W       = $clog2(MAX_LEVELS);
  localparam int LIN_W       = LINEAR_FRAC_BITS + 1;
  localparam int STEP_W      = $clog2(POSITION_FRAC_BITS + 1);
  localparam int PROD_W      = LIN_W + IDX_W;

  // fixed port widths
  localparam int FIELD_W     = 17;
  localparam int ENTRY_IDX_W = 8;
  localparam int POS_W       = 16;
  localparam int CNT_W       = 9;
  localparam int CFG_IDX_W   = 1;

  localparam logic [LIN_W-1:0] LIN_ONE = LIN_W'(1) << LINEAR_FRAC_BITS;

  // request opcodes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 1'b1;

  // table read address select
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_TOP,
    RD_NEXT
  } rd_sel_e;

  // result select
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_TOP,
    RES_INTERP,
    RES_UNIFORM
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     mem_we;
    logic     lin_load;
    rd_sel_e  rd_sel;
    logic     hi_load;
    logic     idx_top;
    logic     idx_dec;
    logic     div_init;
    logic     div_step;
    logic     mul_load;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lin_le_rd;
    logic lin_ge_rd;
  } sts_t;

  // clamp a field to 1.0
  function automatic logic [LIN_W-1:0] sat_linear(input logic [FIELD_W-1:0] x);
    logic [LIN_W-1:0] r;
    if (32'(x) > 32'(LIN_ONE)) begin
      r = LIN_ONE;
    end else begin
      r = LIN_W'(x);
    end
    return r;
  endfunction

endpackage

### rtl/ltlp_ctrl.sv
// sequencer for linear_to_level_position: table scan, divider steps, output handoff
// depends on ltlp_pkg
`timescale 1ns / 1ps

module ltlp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic                uniform_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ltlp_pkg::sts_t      sts_i,
  output ltlp_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_LAST,
    S_CHK_LAST,
    S_SCAN,
    S_DIV,
    S_INTERP,
    S_MUL,
    S_UNI,
    S_FINISH
  } state_e;

  state_e                        state_q, state_d;
  logic [ltlp_pkg::STEP_W-1:0]   step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  logic                          in_acc;
  logic                          out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.rd_sel  = ltlp_pkg::RD_ZERO;
    cmd_o.res_sel = ltlp_pkg::RES_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == ltlp_pkg::OP_LOAD) begin
            cmd_o.mem_we = 1'b1;
          end else begin
            cmd_o.lin_load = 1'b1;
            state_d = uniform_i ? S_MUL : S_RD_FIRST;
          end
        end
      end
      // read of first level in flight
      S_RD_FIRST: begin
        cmd_o.rd_sel = ltlp_pkg::RD_ZERO;
        state_d = S_RD_LAST;
      end
      // first level visible, last level requested
      S_RD_LAST: begin
        cmd_o.rd_sel = ltlp_pkg::RD_TOP;
        if (sts_i.lin_le_rd) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = ltlp_pkg::RES_ZERO;
          state_d = S_FINISH;
        end else begin
          state_d = S_CHK_LAST;
        end
      end
      // last level visible, start the downward scan
      S_CHK_LAST: begin
        if (sts_i.lin_ge_rd) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = ltlp_pkg::RES_TOP;
          state_d = S_FINISH;
        end else begin
          cmd_o.hi_load = 1'b1;
          cmd_o.idx_top = 1'b1;
          cmd_o.rd_sel  = ltlp_pkg::RD_NEXT;
          state_d = S_SCAN;
        end
      end
      // stop at the first level from the top that is not above the value
      S_SCAN: begin
        if (sts_i.lin_ge_rd) begin
          cmd_o.div_init = 1'b1;
          step_d  = '0;
          state_d = S_DIV;
        end else begin
          cmd_o.hi_load = 1'b1;
          cmd_o.idx_dec = 1'b1;
          cmd_o.rd_sel  = ltlp_pkg::RD_NEXT;
        end
      end
      // one quotient bit per cycle
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + ltlp_pkg::STEP_W'(1);
        if (step_q == ltlp_pkg::STEP_W'(ltlp_pkg::POSITION_FRAC_BITS - 1)) begin
          state_d = S_INTERP;
        end
      end
      S_INTERP: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = ltlp_pkg::RES_INTERP;
        state_d = S_FINISH;
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d = S_UNI;
      end
      S_UNI: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = ltlp_pkg::RES_UNIFORM;
        state_d = S_FINISH;
      end
      // hand the result to the output register once it is free
      S_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // checks
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (step_q < ltlp_pkg::STEP_W'(ltlp_pkg::POSITION_FRAC_BITS)))
    else $error("divider step count out of range");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !out_valid_q) |-> cmd_o.out_load)
    else $error("finished result not handed off to a free output register");

  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("output valid missing after result load");

endmodule

### rtl/ltlp_dp.sv
// datapath for linear_to_level_position: level table, scan index, divider, scaler
// depends on ltlp_pkg; driven by ltlp_ctrl commands
`timescale 1ns / 1ps

module ltlp_dp (
  input  logic                                 clk_i,
  input  ltlp_pkg::cmd_t                       cmd_i,
  output ltlp_pkg::sts_t                       sts_o,
  input  logic [ltlp_pkg::CNT_W-1:0]           level_count_i,
  input  logic [ltlp_pkg::ENTRY_IDX_W-1:0]     entry_index_i,
  input  logic [ltlp_pkg::FIELD_W-1:0]         entry_value_i,
  input  logic [ltlp_pkg::FIELD_W-1:0]         linear_value_i,
  output logic [ltlp_pkg::POS_W-1:0]           level_position_o
);

  localparam int P     = ltlp_pkg::POSITION_FRAC_BITS;
  localparam int LW    = ltlp_pkg::LIN_W;
  localparam int IW    = ltlp_pkg::IDX_W;
  localparam int EXT_W = ltlp_pkg::PROD_W + P;

  logic [LW-1:0]                mem_q [ltlp_pkg::MAX_LEVELS];
  logic [LW-1:0]                rd_q;
  logic [IW-1:0]                rd_addr;
  logic [LW-1:0]                lin_q;
  logic [LW-1:0]                hi_q;
  logic [IW-1:0]                idx_q, idx_d;
  logic [IW-1:0]                top;
  logic [LW-1:0]                rem_q;
  logic [LW-1:0]                span_q;
  logic                         zspan_q;
  logic [P-1:0]                 quo_q;
  logic [LW:0]                  rem_sh;
  logic                         rem_ge;
  logic [ltlp_pkg::PROD_W-1:0]  prod_q;
  logic [EXT_W-1:0]             prod_ext;
  logic [ltlp_pkg::POS_W-1:0]   res_d, res_q, out_q;
  logic                         slot_ok;

  // last usable index from the level count
  always_comb begin
    if (level_count_i < ltlp_pkg::CNT_W'(2)) begin
      top = IW'(1);
    end else if (level_count_i > ltlp_pkg::CNT_W'(ltlp_pkg::MAX_LEVELS)) begin
      top = IW'(ltlp_pkg::MAX_LEVELS - 1);
    end else begin
      top = IW'(level_count_i - ltlp_pkg::CNT_W'(1));
    end
  end

  // scan index
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_top) begin
      idx_d = top - IW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - IW'(1);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      ltlp_pkg::RD_ZERO: rd_addr = '0;
      ltlp_pkg::RD_TOP:  rd_addr = top;
      ltlp_pkg::RD_NEXT: rd_addr = idx_d;
      default:           rd_addr = '0;
    endcase
  end

  assign slot_ok = (32'(entry_index_i) < 32'(ltlp_pkg::MAX_LEVELS));

  // level table, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && slot_ok) begin
      mem_q[IW'(entry_index_i)] <= ltlp_pkg::sat_linear(entry_value_i);
    end
    rd_q <= mem_q[rd_addr];
  end

  assign sts_o.lin_le_rd = (lin_q <= rd_q);
  assign sts_o.lin_ge_rd = (lin_q >= rd_q);

  // restoring divider step
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, span_q});

  // uniform scaling: lin * top, then rescale to the position format
  assign prod_ext = {prod_q, {P{1'b0}}} >> ltlp_pkg::LINEAR_FRAC_BITS;

  always_comb begin
    case (cmd_i.res_sel)
      ltlp_pkg::RES_ZERO:    res_d = '0;
      ltlp_pkg::RES_TOP:     res_d = ltlp_pkg::POS_W'({top, {P{1'b0}}});
      ltlp_pkg::RES_INTERP:  res_d = ltlp_pkg::POS_W'({idx_q, (zspan_q ? {P{1'b0}} : quo_q)});
      ltlp_pkg::RES_UNIFORM: res_d = ltlp_pkg::POS_W'(prod_ext);
      default:               res_d = '0;
    endcase
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lin_load) begin
      lin_q <= ltlp_pkg::sat_linear(linear_value_i);
    end
    if (cmd_i.hi_load) begin
      hi_q <= rd_q;
    end
    idx_q <= idx_d;
    if (cmd_i.div_init) begin
      rem_q   <= lin_q - rd_q;
      span_q  <= hi_q - rd_q;
      zspan_q <= (hi_q <= rd_q);
      quo_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? LW'(rem_sh - {1'b0, span_q}) : LW'(rem_sh);
      quo_q <= {quo_q[P-2:0], rem_ge};
    end
    if (cmd_i.mul_load) begin
      prod_q <= ltlp_pkg::PROD_W'(lin_q) * ltlp_pkg::PROD_W'(top);
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign level_position_o = out_q;

  // checks
  a_div_rem: assert property (@(posedge clk_i)
    (cmd_i.div_step && !zspan_q) |-> (rem_q < span_q))
    else $error("divider remainder not below span");

  a_div_lo: assert property (@(posedge clk_i)
    cmd_i.div_init |-> (lin_q >= rd_q))
    else $error("interpolation started from a level above the value");

  a_scan_hi: assert property (@(posedge clk_i)
    cmd_i.idx_dec |-> (lin_q < rd_q))
    else $error("scan stepped past a level not above the value");

endmodule

### rtl/linear_to_level_position.sv
// linear_to_level_position: in uniform mode a request goes through a multiply and a
// rescale; in table mode a value at or beyond an end level clamps to that end, and any
// other value runs a downward table scan and the 8-step serial divider; one request in
// flight, and the next is accepted from the cycle after handoff.
// a load keeps the block idle; reset clears the sequencer, uniform_mode=1, level_count=2;
// the level table has no reset and must be loaded before table-mode conversions
`timescale 1ns / 1ps

module linear_to_level_position (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic [ltlp_pkg::ENTRY_IDX_W-1:0]     entry_index_i,
  input  logic [ltlp_pkg::FIELD_W-1:0]         entry_value_i,
  input  logic [ltlp_pkg::FIELD_W-1:0]         linear_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ltlp_pkg::POS_W-1:0]           level_position_o,
  // register write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ltlp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ltlp_pkg::CNT_W-1:0]           cfg_data_i
);

  logic                          uniform_q;
  logic [ltlp_pkg::CNT_W-1:0]    level_count_q;
  ltlp_pkg::cmd_t                cmd;
  ltlp_pkg::sts_t                sts;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uniform_q     <= 1'b1;
      level_count_q <= ltlp_pkg::CNT_W'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ltlp_pkg::CFG_UNIFORM: uniform_q     <= cfg_data_i[0];
        ltlp_pkg::CFG_COUNT:   level_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ltlp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .uniform_i   (uniform_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ltlp_dp u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .level_count_i    (level_count_q),
    .entry_index_i    (entry_index_i),
    .entry_value_i    (entry_value_i),
    .linear_value_i   (linear_value_i),
    .level_position_o (level_position_o)
  );

endmodule

### tb/sv/tb_linear_to_level_position.sv
// self-checking bench for linear_to_level_position: queued load/convert requests,
// bursty sender, stalling receiver and an in-bench position predictor
// depends on ltlp_pkg and the linear_to_level_position rtl
`timescale 1ns / 1ps

module tb_linear_to_level_position;

  localparam int SETTLE_CYCLES  = 300;   // longest scan plus divider, with margin
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TARGET_ITEMS   = 900;
  localparam int UNIT           = 65536; // 1.0 in Q1.16
  localparam int FIELD_MAX      = 131071;

  typedef struct {
    logic                             op;
    logic [ltlp_pkg::ENTRY_IDX_W-1:0] index;
    logic [ltlp_pkg::FIELD_W-1:0]     entry;
    logic [ltlp_pkg::FIELD_W-1:0]     linear;
  } level_req_t;

  typedef enum int {
    LADDER_RISING,
    LADDER_FLAT_RUNS,
    LADDER_SCRAMBLED
  } ladder_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             op = ltlp_pkg::OP_LOAD;
  logic [ltlp_pkg::ENTRY_IDX_W-1:0] entry_index = '0;
  logic [ltlp_pkg::FIELD_W-1:0]     entry_value = '0;
  logic [ltlp_pkg::FIELD_W-1:0]     linear_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [ltlp_pkg::POS_W-1:0]       level_position;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ltlp_pkg::CFG_IDX_W-1:0]   cfg_index = ltlp_pkg::CFG_UNIFORM;
  logic [ltlp_pkg::CNT_W-1:0]       cfg_data = '0;

  // request queue filled by the stimulus, drained by the driver
  level_req_t request_q[$];
  // positions predicted for accepted converts, oldest first
  logic [ltlp_pkg::POS_W-1:0] pending_positions[$];

  // predictor copy of the block state
  logic                         shadow_uniform = 1'b1;
  logic [ltlp_pkg::CNT_W-1:0]   shadow_count = 9'd2;
  logic [ltlp_pkg::FIELD_W-1:0] level_shadow[ltlp_pkg::MAX_LEVELS];

  // stimulus-side view of the ladder, used to aim converts
  int ladder_plan[ltlp_pkg::MAX_LEVELS];

  int loads_sent = 0;
  int converts_sent = 0;
  int table_converts = 0;
  int reg_writes = 0;
  int positions_checked = 0;
  int mismatches = 0;
  int phases_run = 0;
  int idle_cycles = 0;

  logic hold_kick = 1'b0;

  linear_to_level_position uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .entry_index_i   (entry_index),
    .entry_value_i   (entry_value),
    .linear_value_i  (linear_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .level_position_o(level_position),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // clock and reset
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // values above one read as one
  function automatic logic [ltlp_pkg::FIELD_W-1:0] clamp_unit(
      input logic [ltlp_pkg::FIELD_W-1:0] x);
    return (x > ltlp_pkg::FIELD_W'(UNIT)) ? ltlp_pkg::FIELD_W'(UNIT) : x;
  endfunction

  // expected q8.8 position for a clamped linear value under the shadow state
  function automatic logic [ltlp_pkg::POS_W-1:0] predict_position(
      input logic [ltlp_pkg::FIELD_W-1:0] lin);
    int unsigned top;
    int unsigned k;
    logic [63:0] acc;
    logic [ltlp_pkg::FIELD_W-1:0] lo;
    logic [ltlp_pkg::FIELD_W-1:0] hi;
    if (shadow_count < 2) begin
      top = 1;
    end else if (shadow_count > ltlp_pkg::MAX_LEVELS) begin
      top = ltlp_pkg::MAX_LEVELS - 1;
    end else begin
      top = shadow_count - 1;
    end
    if (shadow_uniform) begin
      acc = ((64'(lin) * 64'(top)) << ltlp_pkg::POSITION_FRAC_BITS)
            >> ltlp_pkg::LINEAR_FRAC_BITS;
      return acc[ltlp_pkg::POS_W-1:0];
    end
    if (lin <= level_shadow[0]) return '0;
    if (lin >= level_shadow[top]) begin
      return ltlp_pkg::POS_W'(top << ltlp_pkg::POSITION_FRAC_BITS);
    end
    // last level at or below the value, table order not assumed
    k = 0;
    for (int unsigned i = 0; i < top; i++) begin
      if (level_shadow[i] <= lin) k = i;
    end
    lo = level_shadow[k];
    hi = level_shadow[k + 1];
    acc = 64'(k) << ltlp_pkg::POSITION_FRAC_BITS;
    if (hi > lo) begin
      acc = acc + ((64'(lin - lo) << ltlp_pkg::POSITION_FRAC_BITS) / 64'(hi - lo));
    end
    return acc[ltlp_pkg::POS_W-1:0];
  endfunction

  task automatic push_load(input logic [ltlp_pkg::ENTRY_IDX_W-1:0] idx, input int raw);
    level_req_t r;
    r.op = ltlp_pkg::OP_LOAD;
    r.index = idx;
    r.entry = ltlp_pkg::FIELD_W'(raw);
    r.linear = ltlp_pkg::FIELD_W'($urandom_range(0, FIELD_MAX));
    request_q = {request_q, r};
    ladder_plan[idx] = (raw > UNIT) ? UNIT : raw;
    loads_sent++;
  endtask

  task automatic push_convert(input int lin);
    level_req_t r;
    r.op = ltlp_pkg::OP_CONVERT;
    r.index = ltlp_pkg::ENTRY_IDX_W'($urandom_range(0, ltlp_pkg::MAX_LEVELS - 1));
    r.entry = ltlp_pkg::FIELD_W'($urandom_range(0, FIELD_MAX));
    r.linear = ltlp_pkg::FIELD_W'(lin);
    request_q = {request_q, r};
    converts_sent++;
  endtask

  // fill slots 0..n-1 with a fresh ladder
  task automatic load_ladder(input int n, input ladder_kind_e kind, input int start_lo);
    int v;
    int step_max;
    int raw;
    v = $urandom_range(start_lo, 1500);
    step_max = 2 * UNIT / n;
    for (int s = 0; s < n; s++) begin
      if (kind == LADDER_SCRAMBLED) begin
        raw = $urandom_range(0, 80000);
      end else begin
        if (s > 0 && !(kind == LADDER_FLAT_RUNS && $urandom_range(0, 2) == 0)) begin
          v += $urandom_range(1, step_max);
        end
        if (v > UNIT) v = UNIT;
        raw = (v == UNIT && $urandom_range(0, 1) == 1) ? $urandom_range(UNIT, FIELD_MAX) : v;
      end
      push_load(ltlp_pkg::ENTRY_IDX_W'(s), raw);
    end
  endtask

  // wait until all requests are taken and all positions are back, then let the block go quiet
  task automatic settle();
    while (request_q.size() != 0 || in_valid || pending_positions.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ltlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ltlp_pkg::CNT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(input logic uni, input logic [ltlp_pkg::CNT_W-1:0] cnt);
    settle();
    write_reg(ltlp_pkg::CFG_UNIFORM, ltlp_pkg::CNT_W'(uni));
    write_reg(ltlp_pkg::CFG_COUNT, cnt);
    phases_run++;
  endtask

  // stimulus
  initial begin
    int n_items;
    int eff;
    int top;
    int sel;
    int j;
    int lin;
    int pick;
    int phase;
    logic uni;
    logic [ltlp_pkg::CNT_W-1:0] cnt;

    while (rst_n !== 1'b1) @(posedge clk);
    @(posedge clk);

    // uniform scaling, two levels, field extremes
    setup(1'b1, 9'd2);
    push_convert(0);
    push_convert(1);
    push_convert(32768);
    push_convert(65535);
    push_convert(UNIT);
    push_convert(UNIT + 1);
    push_convert(FIELD_MAX);

    // uniform with an oversized count
    setup(1'b1, 9'd511);
    push_convert(UNIT);
    push_convert(65535);
    push_convert(257);

    // full table, rising ladder with a nonzero first level
    setup(1'b0, 9'd256);
    load_ladder(ltlp_pkg::MAX_LEVELS, LADDER_RISING, 1);
    push_convert(0);
    push_convert(ladder_plan[0]);
    push_convert(ladder_plan[0] + 1);
    push_convert(ladder_plan[ltlp_pkg::MAX_LEVELS-1] - 1);
    push_convert(ladder_plan[ltlp_pkg::MAX_LEVELS-1]);
    push_convert(FIELD_MAX);

    // short ladder with a repeated level and a saturated top
    setup(1'b0, 9'd4);
    push_load(8'd0, 100);
    push_load(8'd1, 5000);
    push_load(8'd2, 5000);
    push_load(8'd3, 70000);
    push_convert(99);
    push_convert(100);
    push_convert(4999);
    push_convert(5000);
    push_convert(5001);
    push_convert(UNIT);

    // out-of-order ladder
    push_load(8'd0, 100);
    push_load(8'd1, 9000);
    push_load(8'd2, 3000);
    push_load(8'd3, 40000);
    push_convert(5000);
    push_convert(9500);
    push_convert(2500);
    push_convert(39999);

    // random phases
    phase = 0;
    while (loads_sent + converts_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        case ($urandom_range(0, 5))
          0: cnt = 9'd0;
          1: cnt = 9'd1;
          2: cnt = 9'd2;
          3: cnt = 9'd256;
          4: cnt = 9'd257;
          default: cnt = 9'd511;
        endcase
      end else if (pick < 85) begin
        cnt = ltlp_pkg::CNT_W'($urandom_range(2, 16));
      end else begin
        cnt = ltlp_pkg::CNT_W'($urandom_range(17, 255));
      end
      uni = ($urandom_range(0, 3) == 0);
      eff = (cnt < 2) ? 2 : (cnt > ltlp_pkg::MAX_LEVELS) ? ltlp_pkg::MAX_LEVELS : int'(cnt);
      top = eff - 1;
      setup(uni, cnt);

      // receiver holds off once while the sender keeps offering
      if (phase == 2) hold_kick <= 1'b1;

      if (!uni && $urandom_range(0, 9) < ((eff > 64) ? 3 : 7)) begin
        load_ladder(eff, ladder_kind_e'($urandom_range(0, 2)), 0);
      end
      n_items = (eff > 64 && !uni) ? $urandom_range(8, 16) : $urandom_range(20, 60);
      if (phase == 2) n_items = 60;

      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          push_load(ltlp_pkg::ENTRY_IDX_W'($urandom_range(0, ltlp_pkg::MAX_LEVELS - 1)),
                    int'($urandom_range(0, FIELD_MAX)));
        end else begin
          sel = $urandom_range(0, 9);
          if (sel == 0) begin
            lin = $urandom_range(UNIT + 1, FIELD_MAX);
          end else if (sel < 3) begin
            lin = $urandom_range(0, UNIT);
          end else if (uni) begin
            lin = (sel == 3) ? 0 : (sel == 4) ? UNIT : int'($urandom_range(0, UNIT));
          end else begin
            // aim at or next to a level
            j = (sel == 3) ? 0 : (sel == 4) ? top : int'($urandom_range(0, top));
            lin = ladder_plan[j] + int'($urandom_range(0, 6)) - 3;
            if (lin < 0) lin = 0;
          end
          push_convert(lin);
        end
      end
      phase++;
    end

    settle();
    if (pending_positions.size() != 0) mismatches++;
    $display("run covered %0d loads and %0d converts (%0d table lookups) over %0d setups",
             loads_sent, converts_sent, table_converts, phases_run);
    $display("%0d register writes, %0d positions checked, %0d mismatches",
             reg_writes, positions_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // request driver: bursts of random length with random gaps
  always @(posedge clk or negedge rst_n) begin
    level_req_t nr;
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 8;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        nr = request_q.pop_front();
        op <= nr.op;
        entry_index <= nr.index;
        entry_value <= nr.entry;
        linear_value <= nr.linear;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // occasional long gapless stretch
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(1, 12);
          gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: rotating stall pattern, plus one long hold-off
  always @(posedge clk or negedge rst_n) begin
    logic [7:0] stall_pat;
    int pat_left;
    int hold_left;
    logic hold_done;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_pat = 8'hFF;
      pat_left = 32;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_kick && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
      pat_left--;
      if (pat_left <= 0) begin
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        pat_left = $urandom_range(16, 64);
      end
    end
  end

  // monitor: register writes, accepted requests and returned positions
  always @(posedge clk) begin
    logic [ltlp_pkg::POS_W-1:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ltlp_pkg::CFG_UNIFORM) begin
          shadow_uniform = cfg_data[0];
        end else begin
          shadow_count = cfg_data;
        end
        reg_writes++;
      end

      if (in_valid && in_ready) begin
        if (op == ltlp_pkg::OP_LOAD) begin
          level_shadow[entry_index] = clamp_unit(entry_value);
        end else begin
          pending_positions = {pending_positions,
                               predict_position(clamp_unit(linear_value))};
          if (!shadow_uniform) table_converts++;
        end
      end

      if (out_valid && out_ready) begin
        positions_checked++;
        if (pending_positions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected position %0d with nothing pending", level_position);
          end
        end else begin
          want = pending_positions.pop_front();
          if (level_position !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("position mismatch: expected %0d (0x%04h) got %0d (0x%04h)",
                       want, want, level_position, level_position);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d positions pending",
               idle_cycles, pending_positions.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
